@@ rtl/core/r2ntt_pkg.sv @@
// Shared constants, command codes and sequencer states of the radix-2 transform block.
package r2ntt_pkg;

  localparam int POINTS_DEF = 256;
  localparam int VAL_W = 31;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_XFORM = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_ROOT    = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [VAL_W-1:0] MODULUS_RST = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] ROOT_RST    = 31'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_WAIT,
    ST_RD_OUT,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_WAIT,
    ST_RT_MUL,
    ST_RT_WAIT,
    ST_EU_RT_GO,
    ST_EU_RT_WAIT,
    ST_PC_MUL,
    ST_PC_WAIT,
    ST_EU_PC_GO,
    ST_EU_PC_WAIT,
    ST_TW_WR,
    ST_TW_WAIT,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_WAIT,
    ST_BF_WRLO,
    ST_BF_WRHI,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/radix2_number_theoretic_transform.sv @@
// Top level: in-place radix-2 number theoretic transform over a point memory.
//
// Input words on s_*: a load writes a residue at the bit-reversed position of
// its index, a read returns one stored point, and a transform runs all
// butterfly stages in place and returns one done word. Results leave on m_*
// from an output register; cfg_* writes the modulus and the root, which the
// user must write only while idle: the block itself does not enforce it.
// All modular products go through one bit-serial multiplier. A forward
// transform runs a reduction sweep, fills the twiddle table and then runs the
// butterflies, each of which reads two points at once from the dual-read
// point memory and writes them back one after the other. An inverse
// transform adds two inverse computations on the shared divider and a
// scaling sweep.
// Reset clears the sequencer, its counters and the output valid flag and
// restores the modulus and root; the point and twiddle memories are not
// cleared. When the receiver stalls, the finished word is held in the output
// register; a pending read or transform waits for it to be taken first.
module radix2_number_theoretic_transform #(
  parameter int POINTS = r2ntt_pkg::POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // point_index[7:0], point_value[38:8], zero[39]
  input  logic [2:0]  s_tuser,   // cmd[1:0], inverse[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[30:0], zero[31]
  output logic        m_tuser,   // kind[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int VW    = r2ntt_pkg::VAL_W;
  localparam int LOG   = $clog2(POINTS);
  localparam int HALF  = POINTS / 2;
  localparam int TW_AW = (LOG > 1) ? LOG - 1 : 1;
  localparam int LVW   = (LOG > 1) ? $clog2(LOG) : 1;

  r2ntt_pkg::state_t state, state_next;

  logic [VW-1:0] modulus, root;
  logic [VW-1:0] q;

  logic [VW-1:0] pmem [POINTS];
  logic [VW-1:0] twmem [HALF];
  logic [VW-1:0] pa_q, pb_q, tw_q;

  logic [LOG-1:0]   pa_addr, pb_addr, pw_addr;
  logic             pw_en;
  logic [VW-1:0]    pw_data;
  logic [TW_AW-1:0] tw_raddr;
  logic             tw_we;

  logic          mm_start, mm_busy, mm_done;
  logic [4:0]    mm_cnt;
  logic [VW-1:0] mm_a, mm_b, mm_a_in, mm_b_in, mm_r;
  logic [32:0]   mm_r2, mm_rn;

  logic               eu_start, eu_busy, eu_div, eu_done;
  logic [VW-1:0]      eu_a_in, eu_r0, eu_r1, eu_res, eu_r0n;
  logic signed [32:0] eu_t0, eu_t1, eu_t0n;
  logic [60:0]        eu_d;
  logic signed [62:0] eu_dt;
  logic [4:0]         eu_cnt;
  logic               eu_take;
  logic [32:0]        eu_tsel;

  logic             inv_r, pass;
  logic [LOG-1:0]   cnt, addr_r;
  logic [VW-1:0]    k_r, base, w, lo, nlo, nhi;
  logic [LVW-1:0]   lvl;
  logic [TW_AW-1:0] bfly;
  logic [LOG-1:0]   bx, lmask, i_lo, i_hi;
  logic [LVW-1:0]   tw_sh;
  logic [LOG-1:0]   tw_full;
  logic [31:0]      bf_sum;

  logic [1:0]     in_cmd;
  logic [23:0]    idx_ext;
  logic [LOG-1:0] idx, idx_rev;
  logic           in_acc;

  logic          out_load, out_kind;
  logic [VW-1:0] out_val, m_val;

  assign q = (modulus < 31'd2) ? 31'd2 : modulus;

  assign in_cmd  = s_tuser[1:0];
  assign idx_ext = {16'b0, s_tdata[7:0]};
  assign idx     = idx_ext[LOG-1:0];
  assign in_acc  = s_tvalid & s_tready;

  always_comb begin
    for (int k = 0; k < LOG; k++) begin
      idx_rev[k] = idx[LOG-1-k];
    end
  end

  assign bx      = LOG'(bfly);
  assign lmask   = (LOG'(1) << lvl) - LOG'(1);
  assign i_lo    = ((bx & ~lmask) << 1) | (bx & lmask);
  assign i_hi    = i_lo | (LOG'(1) << lvl);
  assign tw_sh   = LVW'(LOG - 1) - lvl;
  assign tw_full = (bx & lmask) << tw_sh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= r2ntt_pkg::MODULUS_RST;
      root    <= r2ntt_pkg::ROOT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == r2ntt_pkg::CFG_MODULUS) begin
        modulus <= cfg_data;
      end else begin
        root <= cfg_data;
      end
    end
  end

  // Point memory: two registered read ports, one write port.
  always_ff @(posedge clk) begin
    if (pw_en) begin
      pmem[pw_addr] <= pw_data;
    end
    pa_q <= pmem[pa_addr];
    pb_q <= pmem[pb_addr];
  end

  always_ff @(posedge clk) begin
    if (tw_we) begin
      twmem[cnt[TW_AW-1:0]] <= w;
    end
    tw_q <= twmem[tw_raddr];
  end

  // Bit-serial modular multiplier: a * b mod q for a below q, one bit of b a cycle.
  assign mm_r2 = {1'b0, mm_r, 1'b0} + (mm_b[mm_cnt] ? {2'b0, mm_a} : 33'd0);
  always_comb begin
    if (mm_r2 >= {1'b0, q, 1'b0}) begin
      mm_rn = mm_r2 - {1'b0, q, 1'b0};
    end else if (mm_r2 >= {2'b0, q}) begin
      mm_rn = mm_r2 - {2'b0, q};
    end else begin
      mm_rn = mm_r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_busy <= 1'b0;
      mm_done <= 1'b0;
    end else begin
      mm_done <= 1'b0;
      if (mm_start) begin
        mm_busy <= 1'b1;
        mm_cnt  <= 5'd30;
        mm_a    <= mm_a_in;
        mm_b    <= mm_b_in;
        mm_r    <= '0;
      end else if (mm_busy) begin
        mm_r <= mm_rn[VW-1:0];
        if (mm_cnt == 5'd0) begin
          mm_busy <= 1'b0;
          mm_done <= 1'b1;
        end else begin
          mm_cnt <= mm_cnt - 5'd1;
        end
      end
    end
  end

  // Extended Euclid with a shift-subtract divider; the inverse is zero when none exists.
  assign eu_take = {30'b0, eu_r0} >= eu_d;
  assign eu_r0n  = eu_take ? eu_r0 - eu_d[VW-1:0] : eu_r0;
  assign eu_t0n  = eu_take ? eu_t0 - $signed(eu_dt[32:0]) : eu_t0;
  assign eu_tsel = eu_t0[32] ? 33'(eu_t0) + {2'b0, q} : 33'(eu_t0);

  always_ff @(posedge clk) begin
    if (rst) begin
      eu_busy <= 1'b0;
      eu_div  <= 1'b0;
      eu_done <= 1'b0;
    end else begin
      eu_done <= 1'b0;
      if (eu_start) begin
        eu_r0   <= q;
        eu_r1   <= eu_a_in;
        eu_t0   <= 33'sd0;
        eu_t1   <= 33'sd1;
        eu_busy <= 1'b1;
        eu_div  <= 1'b0;
      end else if (eu_busy) begin
        if (!eu_div) begin
          if (eu_r1 == '0) begin
            eu_busy <= 1'b0;
            eu_done <= 1'b1;
            if (eu_r0 == 31'd1 && eu_tsel != {2'b0, q}) begin
              eu_res <= eu_tsel[VW-1:0];
            end else begin
              eu_res <= '0;
            end
          end else begin
            eu_d   <= {eu_r1, 30'b0};
            eu_dt  <= 63'(eu_t1) <<< 30;
            eu_cnt <= 5'd30;
            eu_div <= 1'b1;
          end
        end else begin
          eu_d  <= eu_d >> 1;
          eu_dt <= eu_dt >>> 1;
          if (eu_cnt == 5'd0) begin
            eu_div <= 1'b0;
            eu_r0  <= eu_r1;
            eu_r1  <= eu_r0n;
            eu_t0  <= eu_t1;
            eu_t1  <= eu_t0n;
          end else begin
            eu_r0  <= eu_r0n;
            eu_t0  <= eu_t0n;
            eu_cnt <= eu_cnt - 5'd1;
          end
        end
      end
    end
  end

  assign bf_sum = {1'b0, lo} + {1'b0, mm_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2ntt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      r2ntt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == r2ntt_pkg::CMD_LOAD) begin
            state_next = r2ntt_pkg::ST_LD_WAIT;
          end else if (in_cmd == r2ntt_pkg::CMD_XFORM) begin
            state_next = r2ntt_pkg::ST_SC_RD;
          end else if (in_cmd == r2ntt_pkg::CMD_READ) begin
            state_next = r2ntt_pkg::ST_RD_OUT;
          end
        end
      end
      r2ntt_pkg::ST_LD_WAIT: begin
        if (mm_done) state_next = r2ntt_pkg::ST_IDLE;
      end
      r2ntt_pkg::ST_RD_OUT: begin
        if (!m_tvalid || m_tready) state_next = r2ntt_pkg::ST_IDLE;
      end
      r2ntt_pkg::ST_SC_RD:  state_next = r2ntt_pkg::ST_SC_MUL;
      r2ntt_pkg::ST_SC_MUL: state_next = r2ntt_pkg::ST_SC_WAIT;
      r2ntt_pkg::ST_SC_WAIT: begin
        if (mm_done) begin
          if (cnt != LOG'(POINTS - 1)) begin
            state_next = r2ntt_pkg::ST_SC_RD;
          end else if (pass) begin
            state_next = r2ntt_pkg::ST_DONE;
          end else begin
            state_next = r2ntt_pkg::ST_RT_MUL;
          end
        end
      end
      r2ntt_pkg::ST_RT_MUL: state_next = r2ntt_pkg::ST_RT_WAIT;
      r2ntt_pkg::ST_RT_WAIT: begin
        if (mm_done) begin
          state_next = inv_r ? r2ntt_pkg::ST_EU_RT_GO : r2ntt_pkg::ST_TW_WR;
        end
      end
      r2ntt_pkg::ST_EU_RT_GO: state_next = r2ntt_pkg::ST_EU_RT_WAIT;
      r2ntt_pkg::ST_EU_RT_WAIT: begin
        if (eu_done) state_next = r2ntt_pkg::ST_PC_MUL;
      end
      r2ntt_pkg::ST_PC_MUL: state_next = r2ntt_pkg::ST_PC_WAIT;
      r2ntt_pkg::ST_PC_WAIT: begin
        if (mm_done) state_next = r2ntt_pkg::ST_EU_PC_GO;
      end
      r2ntt_pkg::ST_EU_PC_GO: state_next = r2ntt_pkg::ST_EU_PC_WAIT;
      r2ntt_pkg::ST_EU_PC_WAIT: begin
        if (eu_done) state_next = r2ntt_pkg::ST_TW_WR;
      end
      r2ntt_pkg::ST_TW_WR: state_next = r2ntt_pkg::ST_TW_WAIT;
      r2ntt_pkg::ST_TW_WAIT: begin
        if (mm_done) begin
          state_next = (cnt == LOG'(HALF - 1)) ? r2ntt_pkg::ST_BF_RD : r2ntt_pkg::ST_TW_WR;
        end
      end
      r2ntt_pkg::ST_BF_RD:  state_next = r2ntt_pkg::ST_BF_MUL;
      r2ntt_pkg::ST_BF_MUL: state_next = r2ntt_pkg::ST_BF_WAIT;
      r2ntt_pkg::ST_BF_WAIT: begin
        if (mm_done) state_next = r2ntt_pkg::ST_BF_WRLO;
      end
      r2ntt_pkg::ST_BF_WRLO: state_next = r2ntt_pkg::ST_BF_WRHI;
      r2ntt_pkg::ST_BF_WRHI: begin
        if (bfly == TW_AW'(HALF - 1) && lvl == LVW'(LOG - 1)) begin
          state_next = inv_r ? r2ntt_pkg::ST_SC_RD : r2ntt_pkg::ST_DONE;
        end else begin
          state_next = r2ntt_pkg::ST_BF_RD;
        end
      end
      r2ntt_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = r2ntt_pkg::ST_IDLE;
      end
      default: state_next = r2ntt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    pa_addr  = addr_r;
    pb_addr  = i_hi;
    tw_raddr = tw_full[TW_AW-1:0];
    pw_en    = 1'b0;
    pw_addr  = cnt;
    pw_data  = mm_r;
    tw_we    = 1'b0;
    mm_start = 1'b0;
    mm_a_in  = 31'd1;
    mm_b_in  = s_tdata[38:8];
    eu_start = 1'b0;
    eu_a_in  = base;
    out_load = 1'b0;
    out_kind = r2ntt_pkg::KIND_DONE;
    out_val  = '0;
    unique case (state)
      r2ntt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        pa_addr  = idx;
        mm_start = in_acc && (in_cmd == r2ntt_pkg::CMD_LOAD);
      end
      r2ntt_pkg::ST_LD_WAIT: begin
        pw_en   = mm_done;
        pw_addr = addr_r;
      end
      r2ntt_pkg::ST_RD_OUT: begin
        out_load = !m_tvalid || m_tready;
        out_kind = r2ntt_pkg::KIND_READ;
        out_val  = pa_q;
      end
      r2ntt_pkg::ST_SC_RD: pa_addr = cnt;
      r2ntt_pkg::ST_SC_MUL: begin
        mm_start = 1'b1;
        mm_a_in  = k_r;
        mm_b_in  = pa_q;
      end
      r2ntt_pkg::ST_SC_WAIT: pw_en = mm_done;
      r2ntt_pkg::ST_RT_MUL: begin
        mm_start = 1'b1;
        mm_b_in  = root;
      end
      r2ntt_pkg::ST_EU_RT_GO: eu_start = 1'b1;
      r2ntt_pkg::ST_PC_MUL: begin
        mm_start = 1'b1;
        mm_b_in  = VW'(POINTS);
      end
      r2ntt_pkg::ST_EU_PC_GO: begin
        eu_start = 1'b1;
        eu_a_in  = k_r;
      end
      r2ntt_pkg::ST_TW_WR: begin
        tw_we    = 1'b1;
        mm_start = 1'b1;
        mm_a_in  = w;
        mm_b_in  = base;
      end
      r2ntt_pkg::ST_BF_RD: pa_addr = i_lo;
      r2ntt_pkg::ST_BF_MUL: begin
        mm_start = 1'b1;
        mm_a_in  = tw_q;
        mm_b_in  = pb_q;
      end
      r2ntt_pkg::ST_BF_WRLO: begin
        pw_en   = 1'b1;
        pw_addr = i_lo;
        pw_data = nlo;
      end
      r2ntt_pkg::ST_BF_WRHI: begin
        pw_en   = 1'b1;
        pw_addr = i_hi;
        pw_data = nhi;
      end
      r2ntt_pkg::ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // Sequencer registers: counters, address, scale factor, twiddle power and butterfly operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_r <= 1'b0;
      pass  <= 1'b0;
      cnt   <= '0;
      lvl   <= '0;
      bfly  <= '0;
    end else begin
      unique case (state)
        r2ntt_pkg::ST_IDLE: begin
          if (in_acc) begin
            addr_r <= (in_cmd == r2ntt_pkg::CMD_LOAD) ? idx_rev : idx;
            inv_r  <= s_tuser[2];
            pass   <= 1'b0;
            cnt    <= '0;
            k_r    <= 31'd1;
          end
        end
        r2ntt_pkg::ST_SC_WAIT: begin
          if (mm_done) cnt <= cnt + LOG'(1);
        end
        r2ntt_pkg::ST_RT_WAIT: begin
          if (mm_done) begin
            base <= mm_r;
            w    <= 31'd1;
            cnt  <= '0;
          end
        end
        r2ntt_pkg::ST_EU_RT_WAIT: begin
          if (eu_done) base <= eu_res;
        end
        r2ntt_pkg::ST_PC_WAIT: begin
          if (mm_done) k_r <= mm_r;
        end
        r2ntt_pkg::ST_EU_PC_WAIT: begin
          if (eu_done) k_r <= eu_res;
        end
        r2ntt_pkg::ST_TW_WAIT: begin
          if (mm_done) begin
            w    <= mm_r;
            cnt  <= cnt + LOG'(1);
            lvl  <= '0;
            bfly <= '0;
          end
        end
        r2ntt_pkg::ST_BF_MUL: lo <= pa_q;
        r2ntt_pkg::ST_BF_WAIT: begin
          if (mm_done) begin
            nlo <= (bf_sum >= {1'b0, q}) ? VW'(bf_sum - {1'b0, q}) : bf_sum[VW-1:0];
            nhi <= (lo >= mm_r) ? lo - mm_r : lo + q - mm_r;
          end
        end
        r2ntt_pkg::ST_BF_WRHI: begin
          if (bfly == TW_AW'(HALF - 1)) begin
            bfly <= '0;
            if (lvl == LVW'(LOG - 1)) begin
              pass <= 1'b1;
              cnt  <= '0;
            end else begin
              lvl <= lvl + LVW'(1);
            end
          end else begin
            bfly <= bfly + TW_AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tuser  <= out_kind;
      m_val    <= out_val;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {1'b0, m_val};

endmodule

@@ tb/radix2_number_theoretic_transform_tb.sv @@
// Self-checking testbench for the radix-2 number theoretic transform block.
module radix2_number_theoretic_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int NPTS = 256;
  localparam int HALF = NPTS / 2;
  localparam longint CYCLE_LIMIT = 6000000;

  class ntt_scoreboard;
    logic [30:0] points[NPTS];
    logic [30:0] modulus_reg;
    logic [30:0] root_reg;
    logic [31:0] pending_words[$];
    int errors;

    function new();
      modulus_reg = r2ntt_pkg::MODULUS_RST;
      root_reg = r2ntt_pkg::ROOT_RST;
      errors = 0;
    endfunction

    function longint unsigned eff_q();
      return (modulus_reg < 2) ? 64'd2 : longint'(modulus_reg);
    endfunction

    function longint unsigned inv_mod(longint unsigned a, longint unsigned q);
      longint r0, r1, t0, t1, k, r2, t2;
      r0 = q;
      r1 = a % q;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        k = r0 / r1;
        r2 = r0 - k * r1;
        t2 = t0 - k * t1;
        r0 = r1; r1 = r2;
        t0 = t1; t1 = t2;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 += q;
      return longint'(t0) % q;
    endfunction

    function void write_reg(logic idx, logic [30:0] data);
      if (idx == r2ntt_pkg::CFG_MODULUS) modulus_reg = data;
      else root_reg = data;
    endfunction

    function void run_transform(bit inv);
      longint unsigned q, w, u, neg_u, hi, lo, ipc;
      longint unsigned fwd[HALF];
      longint unsigned bwd[HALF];
      int step, tw, i, j;
      q = eff_q();
      w = 1 % q;
      for (i = 0; i < HALF; i++) begin
        fwd[i] = w;
        bwd[i] = inv_mod(w, q);
        w = (w * (root_reg % q)) % q;
      end
      ipc = inv_mod(NPTS, q);
      for (i = 0; i < NPTS; i++) points[i] = 31'(points[i] % q);
      for (step = 1; step < NPTS; step *= 2) begin
        for (j = 0; j < step; j++) begin
          tw = ((HALF / step) * j) % HALF;
          u = inv ? bwd[tw] : fwd[tw];
          neg_u = (q - u) % q;
          for (i = j; i + step < NPTS; i += 2 * step) begin
            hi = points[i + step];
            lo = points[i];
            points[i + step] = 31'((lo + (neg_u * hi) % q) % q);
            points[i] = 31'((lo + (u * hi) % q) % q);
          end
        end
      end
      if (inv)
        for (i = 0; i < NPTS; i++) points[i] = 31'((longint'(points[i]) * ipc) % q);
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] idx, logic [30:0] val, bit inv);
      logic [7:0] rev;
      for (int b = 0; b < 8; b++) rev[b] = idx[7 - b];
      case (cmd)
        r2ntt_pkg::CMD_LOAD: points[rev] = 31'(longint'(val) % eff_q());
        r2ntt_pkg::CMD_XFORM: begin
          run_transform(inv);
          pending_words.push_back({r2ntt_pkg::KIND_DONE, 31'd0});
        end
        r2ntt_pkg::CMD_READ: pending_words.push_back({r2ntt_pkg::KIND_READ, points[idx]});
        default: ;
      endcase
    endfunction

    function void check_word(logic kind, logic [30:0] val);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d value=%0d", $time, kind, val);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (kind !== want[31]) begin
        $display("%0t: kind mismatch expected %0d actual %0d", $time, want[31], kind);
        errors++;
      end
      if (val !== want[30:0]) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, want[30:0], val);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic [2:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [30:0] cfg_data;

  ntt_scoreboard sb;
  bit no_gaps;
  int words_seen;

  radix2_number_theoretic_transform dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function int pick_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [7:0] idx, logic [30:0] val, bit inv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, val, idx};
    s_tuser <= {inv, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(cmd, idx, val, inv);
  endtask

  task automatic write_cfg(logic idx, logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_burst(int count);
    int xforms, r;
    logic [1:0] cmd;
    xforms = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2 && xforms < 2) begin
        cmd = r2ntt_pkg::CMD_XFORM;
        xforms++;
      end else if (r < 45) cmd = r2ntt_pkg::CMD_LOAD;
      else if (r < 92) cmd = r2ntt_pkg::CMD_READ;
      else cmd = CMD_NONE;
      send_word(cmd, 8'($urandom), 31'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [30:0] mod_set[5];
    logic [30:0] root_set[5];
    mod_set = '{31'd7681, 31'h7FFF_FFFF, 31'd2, 31'd1, 31'd65537};
    root_set = '{31'd62, 31'd2147483646, 31'd1, 31'd2147483646, 31'd3};
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NPTS; i++)
      send_word(r2ntt_pkg::CMD_LOAD, 8'(i), 31'($urandom), 1'($urandom));
    send_word(r2ntt_pkg::CMD_LOAD, 8'd0, 31'd0, 1'b0);
    send_word(r2ntt_pkg::CMD_LOAD, 8'd255, 31'h7FFF_FFFF, 1'b1);
    send_word(r2ntt_pkg::CMD_LOAD, 8'd1, 31'd2147483646, 1'b0);
    send_word(r2ntt_pkg::CMD_READ, 8'd0, 31'h7FFF_FFFF, 1'b1);
    send_word(r2ntt_pkg::CMD_READ, 8'd255, 31'd0, 1'b0);
    send_word(r2ntt_pkg::CMD_READ, 8'd128, 31'd0, 1'b0);
    send_word(CMD_NONE, 8'd255, 31'h7FFF_FFFF, 1'b1);
    send_word(r2ntt_pkg::CMD_XFORM, 8'd0, 31'd0, 1'b0);
    send_word(r2ntt_pkg::CMD_READ, 8'd0, 31'd0, 1'b0);
    send_word(r2ntt_pkg::CMD_READ, 8'd255, 31'd0, 1'b0);
    send_word(r2ntt_pkg::CMD_XFORM, 8'd255, 31'h7FFF_FFFF, 1'b1);
    send_word(r2ntt_pkg::CMD_READ, 8'd1, 31'd0, 1'b0);
    random_burst(60);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_cfg(r2ntt_pkg::CFG_MODULUS, mod_set[p]);
      write_cfg(r2ntt_pkg::CFG_ROOT, root_set[p]);
      no_gaps = (p % 2 == 1);
      send_word(r2ntt_pkg::CMD_XFORM, 8'($urandom), 31'($urandom), 1'b1);
      random_burst(70);
    end

    drain();
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("** radix2_number_theoretic_transform: PASSED **");
    else
      $display("** radix2_number_theoretic_transform: FAILED **");
    $finish;
  end

  initial begin
    int hold;
    bit held;
    m_tready = 1'b0;
    hold = 0;
    held = 1'b0;
    words_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_word(m_tuser, m_tdata[30:0]);
        words_seen++;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (!held && words_seen >= 40 && s_tvalid) begin
        held = 1'b1;
        hold = 3000;
        m_tready <= 1'b0;
      end else if (no_gaps) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 20) == 0) begin
        hold = $urandom_range(10, 120);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** radix2_number_theoretic_transform: FAILED **");
    $finish;
  end

endmodule
